### rtl/yuvp_pkg.sv
// shared types and constants of the yuv 4:2:0 plane psnr block
package yuvp_pkg;

   localparam int unsigned MAX_DIMENSION = 4096;
   localparam int unsigned DIM_W         = 13;
   localparam int unsigned POS_W         = 25;
   localparam int unsigned ACC_W         = 41;
   localparam int unsigned LOG_W         = 22;
   localparam int unsigned PSNR_W        = 15;

   localparam logic [31:0] PEAK_SQ    = 32'd65025;
   localparam logic [31:0] DB_Q16     = 32'd50504453;
   localparam logic [PSNR_W-1:0] PSNR_MAX = 15'd32767;

   localparam logic [1:0] PLANE_Y = 2'd0;
   localparam logic [1:0] PLANE_U = 2'd1;
   localparam logic [1:0] PLANE_V = 2'd2;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] ref_pixel;
      logic [7:0] test_pixel;
   } req_type;

   typedef struct packed {
      logic [1:0]        plane;
      logic [15:0]       frame_index;
      logic [39:0]       squared_error_sum;
      logic [PSNR_W-1:0] psnr_db_q8;
      logic              identical;
   } rsp_type;

endpackage

### rtl/yuv420_plane_psnr.sv
// per-plane sse and psnr of a planar yuv 4:2:0 byte stream
// Each word (one reference and one test byte) is accepted in the idle
// state and then placed in the frame, with its squared difference added,
// in the processing state; no new word is taken until it returns to idle.
// A word that ends the Y, U or V plane also runs the log2 sequencer, which
// shares one 32x32 multiplier: two normalising shift searches and two sets
// of 16 squaring steps, after which the result enters the output register
// once that is free. A plane with zero error skips the sequencer and goes
// from the processing state straight to the output state, entering the
// output register once that is free. Frame size registers take effect for the next word.
module yuv420_plane_psnr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  yuvp_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output yuvp_pkg::rsp_type         rsp_data,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [yuvp_pkg::DIM_W-1:0] csr_wdata
);
   import yuvp_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PROC = 2'd1;
   localparam logic [1:0] S_LOG  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]       st_ff;
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [POS_W-1:0] luma_ff;
   logic [POS_W-1:0] pos_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [15:0]      fc_ff;
   req_type          word_ff;
   rsp_type          pend_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;
   logic             log_start_ff;
   logic [POS_W-1:0] n_ff;
   logic [ACC_W-1:0] sse_ff;

   logic [DIM_W-1:0] cw;
   logic [DIM_W-1:0] ch;
   logic [POS_W-1:0] chroma;
   logic [POS_W-1:0] fsize;
   logic [POS_W-1:0] planes_end;
   logic             pre_wrap;
   logic [POS_W-1:0] p;
   logic [ACC_W-1:0] acc_base;
   logic [15:0]      fc_base;
   logic             in_plane;
   logic signed [16:0] diff;
   logic [16:0]      sq;
   logic [ACC_W-1:0] acc_in;
   logic             emit_y;
   logic             emit_u;
   logic             emit_v;
   logic             emit;
   logic [POS_W:0]   p_next;
   logic             log_done;
   logic [PSNR_W-1:0] log_psnr;

   assign cw = (width_ff == '0) ? DIM_W'(1) :
               (width_ff > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : width_ff;
   assign ch = (height_ff == '0) ? DIM_W'(1) :
               (height_ff > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : height_ff;

   assign chroma     = luma_ff >> 2;
   assign fsize      = luma_ff + (luma_ff >> 1);
   assign planes_end = luma_ff + (chroma << 1);
   assign pre_wrap   = pos_ff >= fsize;
   assign p          = pre_wrap ? '0 : pos_ff;
   assign acc_base   = pre_wrap ? '0 : acc_ff;
   assign fc_base    = pre_wrap ? fc_ff + 16'd1 : fc_ff;
   assign in_plane   = p < planes_end;
   assign diff       = 17'($signed({1'b0, word_ff.ref_pixel})
                           - $signed({1'b0, word_ff.test_pixel}));
   assign sq         = 17'(diff * diff);
   assign acc_in     = acc_base + (in_plane ? ACC_W'(sq) : '0);
   assign emit_y     = in_plane && (p == luma_ff - POS_W'(1));
   assign emit_u     = in_plane && (chroma != '0) && (p == luma_ff + chroma - POS_W'(1));
   assign emit_v     = in_plane && (chroma != '0) && (p == planes_end - POS_W'(1));
   assign emit       = emit_y || emit_u || emit_v;
   assign p_next     = {1'b0, p} + (POS_W+1)'(1);

   yuvp_log u_log (
      .clock   (clock),
      .reset   (reset),
      .start   (log_start_ff),
      .n_val   (n_ff),
      .sse_val (sse_ff),
      .done    (log_done),
      .psnr    (log_psnr)
   );

   always_ff @(posedge clock) begin
      luma_ff <= POS_W'(cw) * POS_W'(ch);
      if (reset) begin
         width_ff  <= DIM_W'(352);
         height_ff <= DIM_W'(288);
      end else if (csr_we) begin
         if (csr_index == REG_FRAME_WIDTH) width_ff <= csr_wdata;
         if (csr_index == REG_FRAME_HEIGHT) height_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         pos_ff       <= '0;
         acc_ff       <= '0;
         fc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         log_start_ff <= 1'b0;
      end else begin
         log_start_ff <= (st_ff == S_PROC) && emit && (acc_in != '0);
         if (st_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (st_ff)
            S_IDLE: begin
               if (req_valid) begin
                  word_ff <= req_data;
                  st_ff   <= S_PROC;
               end
            end
            S_PROC: begin
               if (p_next >= {1'b0, fsize}) begin
                  pos_ff <= '0;
                  acc_ff <= '0;
                  fc_ff  <= fc_base + 16'd1;
               end else begin
                  pos_ff <= p_next[POS_W-1:0];
                  acc_ff <= emit ? '0 : acc_in;
                  fc_ff  <= fc_base;
               end
               pend_ff.plane             <= emit_y ? PLANE_Y : (emit_u ? PLANE_U : PLANE_V);
               pend_ff.frame_index       <= fc_base;
               pend_ff.squared_error_sum <= acc_in[39:0];
               pend_ff.psnr_db_q8        <= PSNR_MAX;
               pend_ff.identical         <= (acc_in == '0);
               n_ff                      <= emit_y ? luma_ff : chroma;
               sse_ff                    <= acc_in;
               if (!emit) begin
                  st_ff <= S_IDLE;
               end else if (acc_in == '0) begin
                  st_ff <= S_OUT;
               end else begin
                  st_ff <= S_LOG;
               end
            end
            S_LOG: begin
               if (log_done) begin
                  pend_ff.psnr_db_q8 <= log_psnr;
                  st_ff              <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff <= pend_ff;
                  st_ff  <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (st_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

### rtl/yuvp_mul.sv
// shared 32 by 32 unsigned multiplier
module yuvp_mul (
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] mul_p
);
   assign mul_p = mul_a * mul_b;
endmodule

### rtl/yuvp_log.sv
// sequencer computing psnr in q8 from plane size and error sum via log2
module yuvp_log (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [yuvp_pkg::POS_W-1:0] n_val,
   input  logic [yuvp_pkg::ACC_W-1:0] sse_val,
   output logic                       done,
   output logic [yuvp_pkg::PSNR_W-1:0] psnr
);
   import yuvp_pkg::*;

   localparam logic [2:0] L_IDLE  = 3'd0;
   localparam logic [2:0] L_NMUL  = 3'd1;
   localparam logic [2:0] L_NORM  = 3'd2;
   localparam logic [2:0] L_SQ    = 3'd3;
   localparam logic [2:0] L_DIFF  = 3'd4;
   localparam logic [2:0] L_SCALE = 3'd5;

   logic [2:0]        st_ff;
   logic [ACC_W-1:0]  x_ff;
   logic [5:0]        e_ff;
   logic [31:0]       m_ff;
   logic [3:0]        cnt_ff;
   logic [LOG_W-1:0]  r_ff;
   logic [LOG_W-1:0]  ln_ff;
   logic [LOG_W-1:0]  d_ff;
   logic              pass_ff;
   logic [ACC_W-1:0]  sse_ff;
   logic [POS_W-1:0]  n_ff;
   logic [PSNR_W-1:0] psnr_ff;
   logic              done_ff;

   logic [31:0]      mul_a;
   logic [31:0]      mul_b;
   logic [63:0]      mul_p;
   logic [32:0]      sq;
   logic [LOG_W-1:0] r_in;
   logic [48:0]      round_sum;
   logic [16:0]      v;

   yuvp_mul u_mul (.mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p));

   always_comb begin
      case (st_ff)
         L_NMUL: begin
            mul_a = {7'd0, n_ff};
            mul_b = PEAK_SQ;
         end
         L_SQ: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         L_SCALE: begin
            mul_a = {10'd0, d_ff};
            mul_b = DB_Q16;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign sq        = mul_p[63:31];
   assign r_in      = r_ff | (LOG_W'(sq[32]) << cnt_ff);
   assign round_sum = {1'b0, mul_p[47:0]} + 49'h0_8000_0000;
   assign v         = round_sum[48:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (st_ff == L_SCALE);
         case (st_ff)
            L_IDLE: begin
               if (start) begin
                  n_ff    <= n_val;
                  sse_ff  <= sse_val;
                  pass_ff <= 1'b0;
                  st_ff   <= L_NMUL;
               end
            end
            L_NMUL: begin
               x_ff  <= mul_p[ACC_W-1:0];
               e_ff  <= 6'(ACC_W - 1);
               st_ff <= L_NORM;
            end
            L_NORM: begin
               if (x_ff[ACC_W-1]) begin
                  m_ff   <= x_ff[ACC_W-1 -: 32];
                  r_ff   <= {e_ff, 16'd0};
                  cnt_ff <= 4'd15;
                  st_ff  <= L_SQ;
               end else begin
                  x_ff <= x_ff << 1;
                  e_ff <= e_ff - 6'd1;
               end
            end
            L_SQ: begin
               m_ff   <= sq[32] ? sq[32:1] : sq[31:0];
               r_ff   <= r_in;
               cnt_ff <= cnt_ff - 4'd1;
               if (cnt_ff == 4'd0) begin
                  if (!pass_ff) begin
                     ln_ff   <= r_in;
                     x_ff    <= sse_ff;
                     e_ff    <= 6'(ACC_W - 1);
                     pass_ff <= 1'b1;
                     st_ff   <= L_NORM;
                  end else begin
                     st_ff <= L_DIFF;
                  end
               end
            end
            L_DIFF: begin
               d_ff  <= (ln_ff > r_ff) ? (ln_ff - r_ff) : '0;
               st_ff <= L_SCALE;
            end
            L_SCALE: begin
               psnr_ff <= (v > {2'd0, PSNR_MAX}) ? PSNR_MAX : v[PSNR_W-1:0];
               st_ff   <= L_IDLE;
            end
            default: st_ff <= L_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign psnr = psnr_ff;
endmodule

### rtl/yuvp_checker.sv
// port-level checks of the yuv 4:2:0 plane psnr block
module yuvp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input yuvp_pkg::rsp_type rsp_data
);
   import yuvp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req word accepted back to back");

   a_identical_psnr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.identical |-> rsp_data.psnr_db_q8 == PSNR_MAX)
      else $error("identical plane without saturated psnr");

   a_identical_sse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.identical |-> rsp_data.squared_error_sum == 40'd0)
      else $error("identical plane with non-zero error sum");

   a_plane_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.plane == PLANE_Y || rsp_data.plane == PLANE_U ||
                    rsp_data.plane == PLANE_V)
      else $error("unknown plane code");
endmodule

bind yuv420_plane_psnr yuvp_checker u_yuvp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
